>>> rtl/core/pphit_pkg.sv
// Shared types and constants for the point-to-polyline hit tester.
package pphit_pkg;

    localparam int COORD_BITS_DEF   = 16;
    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int MAX_POINTS_DEF   = 4096;
    localparam int TOL_BITS         = 16;
    localparam int DIST_BITS        = 33;
    localparam int LEVEL_BITS       = 2;
    localparam int OUT_SEG_BITS     = 11;
    localparam int OUT_ELEM_BITS    = 13;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_DOT  = 2'd1;
    localparam logic [1:0] LEVEL_EDGE = 2'd2;

    // Controller to datapath commands, at most one step per cycle; none while the dividers are busy.
    typedef struct packed {
        logic load_item;   // capture input item, clear point counter on a first-in-segment vertex
        logic start_q;     // start item: load query, clear bests
        logic dot_calc;    // dot distance squares
        logic dot_upd;     // compare and update best dot
        logic edge_prep;   // form AB, AP
        logic edge_dl;     // products for d and L
        logic edge_sum;    // sum d and L
        logic edge_nx;     // numerators d*AB, clamp decision
        logic div_start;   // launch both divisions
        logic edge_fin;    // residual squares
        logic edge_upd;    // compare and update best edge
        logic vtx_done;    // store prev, bump counter
    } pphit_cmd_t;

    typedef struct packed {
        logic has_prev;    // point counter nonzero after first handling
        logic clamp;       // edge distance is an endpoint distance
        logic div_busy;
    } pphit_sts_t;

endpackage

>>> rtl/core/pphit_div.sv
// Radix-2 restoring divider for unsigned values, floor-corrected by the caller.
module pphit_div #(
    parameter int NUM_BITS = 66,
    parameter int DEN_BITS = 34
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [NUM_BITS-1:0] quo,
    output logic                rem_nz
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    // One quotient bit per cycle.
    always_comb begin
        trial    = {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
        diff     = trial - {1'b0, den_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = num;
            rem_next = '0;
            cnt_next = CNT_BITS'(NUM_BITS);
        end else if (cnt_reg != '0) begin
            if (!diff[DEN_BITS]) begin
                rem_next = diff;
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy   = (cnt_reg != '0);
    assign quo    = quo_reg;
    assign rem_nz = (rem_reg != '0);
endmodule

>>> rtl/core/pphit_dp.sv
// Datapath: query state, distance arithmetic, best-hit registers.
module pphit_dp #(
    parameter int COORD_BITS   = pphit_pkg::COORD_BITS_DEF,
    parameter int MAX_SEGMENTS = pphit_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_POINTS   = pphit_pkg::MAX_POINTS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pphit_pkg::pphit_cmd_t                cmd,
    output pphit_pkg::pphit_sts_t                sts,
    input  logic [pphit_pkg::TOL_BITS-1:0]       tol,
    input  logic [1:0]                           in_mode,
    input  logic signed [COORD_BITS-1:0]         in_x,
    input  logic signed [COORD_BITS-1:0]         in_y,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]      in_seg,
    input  logic                                 in_first,
    output logic [pphit_pkg::LEVEL_BITS-1:0]     out_level,
    output logic [pphit_pkg::OUT_SEG_BITS-1:0]   out_seg,
    output logic [pphit_pkg::OUT_ELEM_BITS-1:0]  out_elem,
    output logic [pphit_pkg::DIST_BITS-1:0]      out_dist
);
    localparam int SB = $clog2(MAX_SEGMENTS);
    localparam int PB = $clog2(MAX_POINTS);
    localparam int DB = pphit_pkg::DIST_BITS;
    localparam int DFB = COORD_BITS + 1;          // coordinate differences
    localparam int PRB = 2 * DFB;                 // products of differences
    localparam int SUMB = PRB + 1;                // d and L
    localparam int NB = SUMB + DFB;               // d*AB magnitude
    localparam int RB = NB + 1;                   // residual
    localparam int SQB = 2 * RB + 1;
    localparam logic [DB-1:0] DMAX = '1;
    localparam logic [PB-1:0] PMAX = PB'(MAX_POINTS - 1);

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, px_reg, py_reg, vx_reg, vy_reg;
    logic [SB-1:0] seg_reg;
    logic [PB-1:0] pc_reg;
    logic signed [DFB-1:0] abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;
    logic signed [PRB-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [SUMB-1:0] d_reg, l_reg;
    logic          clamp_reg;
    logic          useb_reg;
    logic [NB-1:0] nxm_reg, nym_reg;
    logic          nxs_reg, nys_reg;
    logic [DB-1:0] dd_cur, de_cur;
    logic [2*DFB-1:0] sqa_reg, sqb_reg;
    logic          bdv_reg, bev_reg;
    logic [DB-1:0] bdd_reg, bed_reg;
    logic [SB-1:0] bds_reg, bes_reg;
    logic [PB-1:0] bdi_reg, bei_reg;
    logic [2*pphit_pkg::TOL_BITS-1:0] tol2;

    logic          bx_busy, by_busy, rx_nz, ry_nz;
    logic [NB-1:0] qxm, qym;
    logic signed [RB-1:0] qxs, qys, rx, ry;
    logic [SQB-1:0] rsq;
    logic [DFB:0]   ax, ay;
    logic [2*DFB+1:0] esq;

    assign tol2 = tol * tol;

    pphit_div #(.NUM_BITS(NB), .DEN_BITS(SUMB)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(nxm_reg), .den(l_reg), .busy(bx_busy), .quo(qxm), .rem_nz(rx_nz));
    pphit_div #(.NUM_BITS(NB), .DEN_BITS(SUMB)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(nym_reg), .den(l_reg), .busy(by_busy), .quo(qym), .rem_nz(ry_nz));

    // Floor division from magnitude quotient, then residual.
    always_comb begin
        qxs = nxs_reg ? -$signed(RB'(qxm)) - RB'(rx_nz) : $signed(RB'(qxm));
        qys = nys_reg ? -$signed(RB'(qym)) - RB'(ry_nz) : $signed(RB'(qym));
        rx  = RB'(apx_reg) - qxs;
        ry  = RB'(apy_reg) - qys;
    end

    // Endpoint distance: A (apx) or B (bpx) by clamp side.
    always_comb begin
        ax = useb_reg ? (DFB+1)'(bpx_reg[DFB-1] ? -bpx_reg : bpx_reg)
                      : (DFB+1)'(apx_reg[DFB-1] ? -apx_reg : apx_reg);
        ay = useb_reg ? (DFB+1)'(bpy_reg[DFB-1] ? -bpy_reg : bpy_reg)
                      : (DFB+1)'(apy_reg[DFB-1] ? -apy_reg : apy_reg);
        esq = (2*DFB+2)'(ax[DFB-1:0] * ax[DFB-1:0]) + (2*DFB+2)'(ay[DFB-1:0] * ay[DFB-1:0]);
    end

    // Residual lies between the query and a point of the edge, so it fits a coordinate difference.
    logic [DFB-1:0] rxa, rya;
    always_comb begin
        rxa = DFB'(rx[RB-1] ? -rx : rx);
        rya = DFB'(ry[RB-1] ? -ry : ry);
        rsq = SQB'(sqa_reg) + SQB'(sqb_reg);
    end

    // Saturated squared distances seen by the update steps.
    always_comb begin
        dd_cur = (rsq > SQB'(DMAX)) ? DMAX : DB'(rsq);
        if (clamp_reg) begin
            de_cur = (SQB'(esq) > SQB'(DMAX)) ? DMAX : DB'(esq);
        end else begin
            de_cur = dd_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg <= '0; qy_reg <= '0; px_reg <= '0; py_reg <= '0;
            pc_reg <= '0;
            bdv_reg <= 1'b0; bev_reg <= 1'b0;
            bdd_reg <= '0; bed_reg <= '0; bds_reg <= '0; bes_reg <= '0;
            bdi_reg <= '0; bei_reg <= '0;
        end else begin
            if (cmd.start_q) begin
                qx_reg <= vx_reg; qy_reg <= vy_reg; pc_reg <= '0;
                bdv_reg <= 1'b0; bev_reg <= 1'b0;
                bdd_reg <= '0; bed_reg <= '0; bds_reg <= '0; bes_reg <= '0;
                bdi_reg <= '0; bei_reg <= '0;
            end
            if (cmd.load_item && in_mode == pphit_pkg::MODE_VERTEX && in_first) begin
                pc_reg <= '0;
            end
            // Best dot: strict improvement only, earlier wins ties.
            if (cmd.dot_upd && dd_cur <= DB'(tol2) && (!bdv_reg || dd_cur < bdd_reg)) begin
                bdv_reg <= 1'b1; bdd_reg <= dd_cur; bds_reg <= seg_reg; bdi_reg <= pc_reg;
            end
            if (cmd.edge_upd && de_cur <= DB'(tol2) && (!bev_reg || de_cur < bed_reg)) begin
                bev_reg <= 1'b1; bed_reg <= de_cur; bes_reg <= seg_reg;
                bei_reg <= pc_reg - 1'b1;
            end
            if (cmd.vtx_done) begin
                px_reg <= vx_reg; py_reg <= vy_reg;
                if (pc_reg < PMAX) begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end
        end
    end

    // Payload pipeline registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            vx_reg <= in_x; vy_reg <= in_y; seg_reg <= in_seg;
        end
        if (cmd.dot_calc) begin
            sqa_reg <= (2*DFB)'((DFB'(qx_reg) - DFB'(vx_reg)) * (DFB'(qx_reg) - DFB'(vx_reg)));
            sqb_reg <= (2*DFB)'((DFB'(qy_reg) - DFB'(vy_reg)) * (DFB'(qy_reg) - DFB'(vy_reg)));
        end
        if (cmd.edge_prep) begin
            abx_reg <= DFB'(vx_reg) - DFB'(px_reg);
            aby_reg <= DFB'(vy_reg) - DFB'(py_reg);
            apx_reg <= DFB'(qx_reg) - DFB'(px_reg);
            apy_reg <= DFB'(qy_reg) - DFB'(py_reg);
            bpx_reg <= DFB'(qx_reg) - DFB'(vx_reg);
            bpy_reg <= DFB'(qy_reg) - DFB'(vy_reg);
        end
        if (cmd.edge_dl) begin
            p0_reg <= apx_reg * abx_reg; p1_reg <= apy_reg * aby_reg;
            p2_reg <= abx_reg * abx_reg; p3_reg <= aby_reg * aby_reg;
        end
        if (cmd.edge_sum) begin
            d_reg <= SUMB'(p0_reg) + SUMB'(p1_reg);
            l_reg <= SUMB'(p2_reg) + SUMB'(p3_reg);
        end
        if (cmd.edge_nx) begin
            // d is positive here when used; magnitude of d*AB.
            clamp_reg <= (l_reg == '0) || (d_reg <= 0) || (d_reg >= l_reg);
            useb_reg  <= !((l_reg == '0) || (d_reg <= 0));
            nxm_reg <= NB'(d_reg[SUMB-2:0]) * NB'(abx_reg[DFB-1] ? -abx_reg : abx_reg);
            nym_reg <= NB'(d_reg[SUMB-2:0]) * NB'(aby_reg[DFB-1] ? -aby_reg : aby_reg);
            nxs_reg <= abx_reg[DFB-1];
            nys_reg <= aby_reg[DFB-1];
        end
        if (cmd.edge_fin) begin
            if (clamp_reg) begin
                sqa_reg <= '0;
                sqb_reg <= '0;
            end else begin
                sqa_reg <= (2*DFB)'(rxa * rxa);
                sqb_reg <= (2*DFB)'(rya * rya);
            end
        end
    end

    assign sts.has_prev = (pc_reg != '0);
    assign sts.clamp    = clamp_reg;
    assign sts.div_busy = bx_busy | by_busy;

    // Report mux.
    always_comb begin
        if (bdv_reg) begin
            out_level = pphit_pkg::LEVEL_DOT;
            out_seg   = pphit_pkg::OUT_SEG_BITS'(bds_reg);
            out_elem  = pphit_pkg::OUT_ELEM_BITS'(bdi_reg);
            out_dist  = bdd_reg;
        end else if (bev_reg) begin
            out_level = pphit_pkg::LEVEL_EDGE;
            out_seg   = pphit_pkg::OUT_SEG_BITS'(bes_reg);
            out_elem  = pphit_pkg::OUT_ELEM_BITS'(bei_reg);
            out_dist  = bed_reg;
        end else begin
            out_level = pphit_pkg::LEVEL_NONE;
            out_seg   = '1;
            out_elem  = '1;
            out_dist  = '0;
        end
    end
endmodule

>>> rtl/core/pphit_ctrl.sv
// Controller: sequences one item through the datapath steps.
module pphit_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            in_mode,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  out_load,
    output pphit_pkg::pphit_cmd_t cmd,
    input  pphit_pkg::pphit_sts_t sts
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_DOT, ST_DUPD, ST_PREP, ST_DL, ST_SUM, ST_NX,
        ST_DIV, ST_WAIT, ST_FIN, ST_EUPD, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   acc;

    assign s_tready = (state_reg == ST_IDLE) && (!mv_reg || m_tready);
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign out_load = acc && in_mode == pphit_pkg::MODE_FINISH;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        mv_next    = mv_reg && !m_tready;
        if (out_load) mv_next = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.load_item = 1'b1;
                    if (in_mode == pphit_pkg::MODE_START) state_next = ST_START;
                    else if (in_mode == pphit_pkg::MODE_VERTEX) state_next = ST_DOT;
                end
            end
            ST_START: begin cmd.start_q = 1'b1; state_next = ST_IDLE; end
            ST_DOT:   begin cmd.dot_calc = 1'b1; state_next = ST_DUPD; end
            ST_DUPD: begin
                cmd.dot_upd = 1'b1;
                state_next  = sts.has_prev ? ST_PREP : ST_DONE;
            end
            ST_PREP: begin cmd.edge_prep = 1'b1; state_next = ST_DL; end
            ST_DL:   begin cmd.edge_dl = 1'b1; state_next = ST_SUM; end
            ST_SUM:  begin cmd.edge_sum = 1'b1; state_next = ST_NX; end
            ST_NX:   begin cmd.edge_nx = 1'b1; state_next = ST_DIV; end
            ST_DIV: begin
                if (sts.clamp) state_next = ST_FIN;
                else begin cmd.div_start = 1'b1; state_next = ST_WAIT; end
            end
            ST_WAIT: if (!sts.div_busy) state_next = ST_FIN;
            ST_FIN:  begin cmd.edge_fin = 1'b1; state_next = ST_EUPD; end
            ST_EUPD: begin cmd.edge_upd = 1'b1; state_next = ST_DONE; end
            ST_DONE: begin cmd.vtx_done = 1'b1; state_next = ST_IDLE; end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end
endmodule

>>> rtl/core/point_polyline_hit_test.sv
// Top level of the point-to-polyline hit tester.
// Usage: write hit_tolerance through cfg_wr_en/cfg_wr_data while idle.
// Input items on s_axis: mode 0 loads the query point and clears the bests,
// mode 1 streams a polyline vertex, mode 2 requests a report, mode 3 is dropped.
// Only a finish item gives a result item on m_axis, in the cycle after accept.
// A start item loads the query; a vertex computes its dot distance and, when it closes
// an edge, the edge projection, which runs two floor divisions of a 52-bit
// numerator in one-bit-per-cycle dividers and waits until both are done.
// An endpoint-clamped edge skips the divider.
// A stalled m_axis holds its result; a new item is accepted only when the
// result register is free or being taken.
// Reset (aresetn low, synchronous) clears the query, counter and bests and
// sets hit_tolerance to 16.
module point_polyline_hit_test #(
    parameter int COORD_BITS   = pphit_pkg::COORD_BITS_DEF,
    parameter int MAX_SEGMENTS = pphit_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_POINTS   = pphit_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coord_x, coord_y, segment_index, zero fill
    input  logic [((2*COORD_BITS+$clog2(MAX_SEGMENTS)+7)/8)*8-1:0] s_tdata,
    // mode, first_in_segment
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_segment, hit_element, hit_distance_sq, zero fill
    output logic [63:0] m_tdata,
    // hit_level
    output logic [1:0]  m_tuser
);
    localparam int SB = $clog2(MAX_SEGMENTS);

    logic [15:0] tol_reg;
    pphit_pkg::pphit_cmd_t cmd;
    pphit_pkg::pphit_sts_t sts;
    logic        out_load;
    logic [1:0]  lvl;
    logic [10:0] oseg;
    logic [12:0] oelem;
    logic [32:0] odist;
    logic [63:0] mdata_reg;
    logic [1:0]  muser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= 16'd16;
        else if (cfg_wr_en) tol_reg <= cfg_wr_data;
    end

    pphit_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_mode(s_tuser[1:0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_load(out_load), .cmd(cmd), .sts(sts));

    pphit_dp #(.COORD_BITS(COORD_BITS), .MAX_SEGMENTS(MAX_SEGMENTS),
               .MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .tol(tol_reg),
        .in_mode(s_tuser[1:0]),
        .in_x(s_tdata[COORD_BITS-1:0]), .in_y(s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_seg(s_tdata[2*COORD_BITS+SB-1:2*COORD_BITS]), .in_first(s_tuser[2]),
        .out_level(lvl), .out_seg(oseg), .out_elem(oelem), .out_dist(odist));

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            mdata_reg <= {7'd0, odist, oelem, oseg};
            muser_reg <= lvl;
        end
    end
    assign m_tdata = mdata_reg;
    assign m_tuser = muser_reg;

    // A result appears only right after a finish item.
    a_out_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |->
            $past(s_tvalid && s_tready && s_tuser[1:0] == pphit_pkg::MODE_FINISH))
        else $error("result without finish");
    // No item taken while a held result is stalled.
    a_no_acc_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("accept during stall");
    // A level of none reports no distance.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == pphit_pkg::LEVEL_NONE) |-> m_tdata[56:24] == 33'd0)
        else $error("none with distance");
endmodule

>>> tb/pphit_checker.sv
// Checker for the point-to-polyline hit tester: predicts reports and compares them.
module pphit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending_reports
);

    localparam longint DIST_SAT = (64'd1 << 33) - 1;

    typedef struct packed {
        logic [1:0]  level;
        logic [10:0] seg;
        logic [12:0] elem;
        logic [32:0] dsq;
    } hit_report_t;

    hit_report_t report_q[$];

    // predictor state
    logic [15:0] tol;
    longint qx, qy, px, py;
    int unsigned pcount;
    bit dot_ok, edge_ok;
    longint dot_d, edge_d;
    int unsigned dot_seg, dot_idx, edge_seg, edge_idx;

    assign pending_reports = report_q.size();

    function automatic longint sq_sat(longint dx, longint dy);
        longint r;
        r = dx * dx + dy * dy;
        return (r > DIST_SAT) ? DIST_SAT : r;
    endfunction

    function automatic longint div_floor(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic longint edge_dist(longint ax, longint ay, longint bx, longint by);
        longint abx, aby, apx, apy, d, len;
        abx = bx - ax; aby = by - ay;
        apx = qx - ax; apy = qy - ay;
        d = apx * abx + apy * aby;
        len = abx * abx + aby * aby;
        if (len == 0 || d <= 0) return sq_sat(apx, apy);
        if (d >= len) return sq_sat(qx - bx, qy - by);
        return sq_sat(apx - div_floor(d * abx, len), apy - div_floor(d * aby, len));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // prediction on accepted input items
    always @(posedge aclk) begin
        longint x, y, tol2, dd, de;
        logic [1:0] mode;
        hit_report_t r;
        if (!aresetn) begin
            tol <= 16'd16;
            qx = 0; qy = 0; px = 0; py = 0; pcount = 0;
            dot_ok = 0; edge_ok = 0; dot_d = 0; edge_d = 0;
            dot_seg = 0; dot_idx = 0; edge_seg = 0; edge_idx = 0;
        end else begin
            if (cfg_wr_en) tol <= cfg_wr_data;
            if (s_tvalid && s_tready) begin
                mode = s_tuser[1:0];
                x = longint'($signed(s_tdata[15:0]));
                y = longint'($signed(s_tdata[31:16]));
                tol2 = longint'(tol) * longint'(tol);
                if (mode == pphit_pkg::MODE_START) begin
                    qx = x; qy = y; pcount = 0;
                    dot_ok = 0; edge_ok = 0; dot_d = 0; edge_d = 0;
                    dot_seg = 0; dot_idx = 0; edge_seg = 0; edge_idx = 0;
                end else if (mode == pphit_pkg::MODE_VERTEX) begin
                    if (s_tuser[2]) pcount = 0;
                    dd = sq_sat(qx - x, qy - y);
                    if (dd <= tol2 && (!dot_ok || dd < dot_d)) begin
                        dot_ok = 1; dot_d = dd;
                        dot_seg = 32'(s_tdata[41:32]); dot_idx = pcount;
                    end
                    if (pcount > 0) begin
                        de = edge_dist(px, py, x, y);
                        if (de <= tol2 && (!edge_ok || de < edge_d)) begin
                            edge_ok = 1; edge_d = de;
                            edge_seg = 32'(s_tdata[41:32]); edge_idx = pcount - 1;
                        end
                    end
                    px = x; py = y;
                    if (pcount < pphit_pkg::MAX_POINTS_DEF - 1) pcount++;
                end else if (mode == pphit_pkg::MODE_FINISH) begin
                    if (dot_ok)
                        r = '{pphit_pkg::LEVEL_DOT, 11'(dot_seg), 13'(dot_idx), 33'(dot_d)};
                    else if (edge_ok)
                        r = '{pphit_pkg::LEVEL_EDGE, 11'(edge_seg), 13'(edge_idx),
                              33'(edge_d)};
                    else
                        r = '{pphit_pkg::LEVEL_NONE, '1, '1, '0};
                    report_q.insert(report_q.size(), r);
                end
            end
        end
    end

    // compare accepted results against the oldest prediction
    always @(posedge aclk) begin
        hit_report_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                w = report_q.pop_front();
                if (m_tuser != w.level)
                    report_mismatch("hit_level", longint'(m_tuser), longint'(w.level));
                if (m_tdata[10:0] != w.seg)
                    report_mismatch("hit_segment", longint'(m_tdata[10:0]), longint'(w.seg));
                if (m_tdata[23:11] != w.elem)
                    report_mismatch("hit_element", longint'(m_tdata[23:11]),
                                    longint'(w.elem));
                if (m_tdata[56:24] != w.dsq)
                    report_mismatch("hit_distance_sq", longint'(m_tdata[56:24]),
                                    longint'(w.dsq));
                if (m_tdata[63:57] != 0)
                    report_mismatch("zero fill", longint'(m_tdata[63:57]), 0);
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the point-to-polyline hit tester: stimulus and verdict.
module tb_top;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = 0;
    logic [2:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count, pending_reports;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    longint      cycle_count = 0;
    int          phase_pct[4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{33, 33}};
    logic [15:0] tol_set[4] = '{16'd0, 16'd65535, 16'd40, 16'd300};

    always #4 aclk = ~aclk;

    point_polyline_hit_test uut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    pphit_checker chk (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .fail_count, .pending_reports
    );

    // receiver stalls at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // send one item, with random idle cycles ahead of it; tvalid stays up after the
    // handshake until the next item or an explicit drop
    task automatic send_item(input logic [1:0] mode, input logic [15:0] x, input logic [15:0] y,
                             input logic [9:0] seg, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {6'd0, seg, y, x};
        s_tuser  <= {first, mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        s_tvalid <= 0;
        while (pending_reports != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    // random coordinate, mostly near the query so hits happen
    function automatic logic [15:0] near(input logic [15:0] c, input int spread);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return c + 16'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    // one query: usually a start, then a few polylines and a finish
    task automatic run_query(input int spread);
        logic [15:0] cx, cy;
        int nseg, nv;
        logic [9:0] seg;
        cx = 16'($urandom); cy = 16'($urandom);
        if ($urandom_range(9) != 0) send_item(pphit_pkg::MODE_START, cx, cy, 10'd0, 1'b0);
        nseg = $urandom_range(3, 1);
        seg = 10'($urandom_range(1023, nseg));
        for (int s = 0; s < nseg; s++) begin
            nv = $urandom_range(4, 1);
            for (int v = 0; v < nv; v++) begin
                if ($urandom_range(19) == 0)
                    send_item(MODE_UNUSED, 16'($urandom), 16'($urandom), 10'($urandom),
                              1'($urandom));
                send_item(pphit_pkg::MODE_VERTEX, near(cx, spread), near(cy, spread), seg,
                          (v == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
            end
            seg = seg - 10'd1;
        end
        send_item(pphit_pkg::MODE_FINISH, 16'($urandom), 16'($urandom), 10'($urandom),
                  1'($urandom));
        if ($urandom_range(9) == 0)
            send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, default tolerance, then maximum tolerance
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_START, 16'h8000, 16'h7fff, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_VERTEX, 16'h8000, 16'h7fff, 10'h3ff, 1'b1);
        send_item(pphit_pkg::MODE_VERTEX, 16'h7fff, 16'h8000, 10'h3ff, 1'b0);
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_START, 16'd0, 16'd0, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_VERTEX, 16'd100, 16'hff9c, 10'd5, 1'b0); // no previous vertex
        send_item(pphit_pkg::MODE_VERTEX, 16'hff9c, 16'd100, 10'd5, 1'b0); // edge through origin
        send_item(pphit_pkg::MODE_VERTEX, 16'hff9c, 16'd100, 10'd5, 1'b0); // zero-length edge
        send_item(MODE_UNUSED, 16'hffff, 16'hffff, 10'h3ff, 1'b1);          // ignored
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_START, 16'h7fff, 16'h8000, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_VERTEX, 16'h8000, 16'h7fff, 10'd1, 1'b1);
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);
        write_tolerance(16'hffff);
        send_item(pphit_pkg::MODE_START, 16'h8000, 16'h8000, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_VERTEX, 16'h7fff, 16'h7fff, 10'd0, 1'b1);
        send_item(pphit_pkg::MODE_VERTEX, 16'h8000, 16'h7fff, 10'd0, 1'b0);
        send_item(pphit_pkg::MODE_FINISH, 16'd0, 16'd0, 10'd0, 1'b0);

        // random phases over several tolerances
        for (int p = 0; p < 4; p++) begin
            for (int t = 0; t < 4; t++) begin
                send_idle_pct  = phase_pct[p][0];
                recv_stall_pct = phase_pct[p][1];
                write_tolerance((t == 3) ? 16'($urandom) : tol_set[t]);
                for (int q = 0; q < 12; q++) run_query((t == 1) ? 4000 : 60);
            end
        end

        s_tvalid <= 0;
        while (pending_reports != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
